### rtl/core/mesh_edge_adjacency_linker_top_defines.svh
// Assertion macros for the mesh edge adjacency linker.
// Used by the top level only; relies on clk and rst_n being in scope.
`ifndef MESH_EDGE_ADJACENCY_LINKER_TOP_DEFINES_SVH
`define MESH_EDGE_ADJACENCY_LINKER_TOP_DEFINES_SVH
// same-cycle implication
`define MEAL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define MEAL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

### rtl/core/meal_pkg.sv
// Shared constants, types and the edge hash for the adjacency linker.
// No dependencies.
package meal_pkg;
    localparam int TABLE_DEPTH = 4096;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int ID_W        = 16;
    localparam int SLOT_W      = 2;
    localparam int EPOCH_W     = 8;
    localparam int ENTRY_W     = EPOCH_W + 3 * ID_W + SLOT_W;

    localparam logic [EPOCH_W-1:0] EPOCH_MAX  = {EPOCH_W{1'b1}};
    localparam logic [EPOCH_W-1:0] EPOCH_NONE = '0;

    typedef struct packed {
        logic load;
        logic start_clear;
        logic sweep_start;
        logic sweep_wr;
        logic epoch_init;
        logic setup_edge;
        logic probe_next;
        logic latch_entry;
        logic write_entry;
        logic push_hit1;
        logic push_hit2;
        logic push_full;
        logic flush;
        logic next_edge;
    } meal_cmd_t;

    typedef struct packed {
        logic start_flag;
        logic epoch_max;
        logic sweep_done;
        logic rd_valid;
        logic rd_match;
        logic probe_last;
        logic edge_last;
        logic count_full;
        logic out_free;
        logic pend_valid;
    } meal_status_t;

    function automatic logic [ADDR_W-1:0] key_slot_hash(input logic [ID_W-1:0] lo,
                                                        input logic [ID_W-1:0] hi);
        logic [ID_W-1:0] mix;
        mix = lo ^ {hi[3:0], hi[ID_W-1:4]} ^ {lo[7:0], hi[ID_W-1:8]};
        return mix[ADDR_W-1:0];
    endfunction
endpackage

### rtl/core/meal_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module meal_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### rtl/core/meal_datapath.sv
// Datapath: face capture, edge keys, hashed probe address, edge RAM,
// entry count, epoch, and the pending/output result registers.
// Depends on meal_pkg and meal_ram.
module meal_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  meal_pkg::meal_cmd_t   cmd,
    output meal_pkg::meal_status_t st,
    input  logic                  in_start,
    input  logic [63:0]           in_data,
    output logic [39:0]           out_data,
    output logic                  out_last,
    output logic                  out_valid,
    input  logic                  out_ready
);
    localparam int IW = meal_pkg::ID_W;
    localparam int AW = meal_pkg::ADDR_W;

    logic                          start_reg;
    logic [IW-1:0]                 face_reg, v0_reg, v1_reg, v2_reg;
    logic [1:0]                    edge_reg;
    logic [IW-1:0]                 lo_reg, hi_reg;
    logic [1:0]                    opp_reg;
    logic [AW-1:0]                 addr_reg, probes_reg, sweep_reg;
    logic [meal_pkg::CNT_W-1:0]    count_reg;
    logic [meal_pkg::EPOCH_W-1:0]  epoch_reg;
    logic [IW-1:0]                 ent_face_reg;
    logic [1:0]                    ent_slot_reg;

    // pending result waits until we know whether it is the last one
    logic [34:0] pend_reg, pend_next;
    logic        pend_v_reg;
    logic [34:0] out_reg;
    logic        out_last_reg, out_v_reg;

    logic [IW-1:0] p, q, lo_c, hi_c;
    logic [1:0]    opp_c;

    always_comb
    begin
        case (edge_reg)
            2'd0:    begin p = v0_reg; q = v1_reg; opp_c = 2'd2; end
            2'd1:    begin p = v1_reg; q = v2_reg; opp_c = 2'd0; end
            default: begin p = v2_reg; q = v0_reg; opp_c = 2'd1; end
        endcase
        lo_c = (p < q) ? p : q;
        hi_c = (p < q) ? q : p;
    end

    // RAM: entry = {epoch, lo, hi, face, slot}
    logic                           ram_we;
    logic [AW-1:0]                  ram_waddr;
    logic [meal_pkg::ENTRY_W-1:0]   ram_wdata, ram_rdata;
    logic [meal_pkg::EPOCH_W-1:0]   rd_epoch;
    logic [IW-1:0]                  rd_lo, rd_hi, rd_face;
    logic [1:0]                     rd_slot;

    assign ram_we    = cmd.sweep_wr || cmd.write_entry;
    assign ram_waddr = cmd.sweep_wr ? sweep_reg : addr_reg;
    assign ram_wdata = cmd.sweep_wr ? '0
                                    : {epoch_reg, lo_reg, hi_reg, face_reg, opp_reg};
    assign {rd_epoch, rd_lo, rd_hi, rd_face, rd_slot} = ram_rdata;

    meal_ram #(
        .WIDTH (meal_pkg::ENTRY_W),
        .DEPTH (meal_pkg::TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        pend_next = pend_reg;
        if (cmd.push_hit1)
        begin
            pend_next = {1'b0, ent_face_reg, opp_reg, face_reg};
        end
        else if (cmd.push_hit2)
        begin
            pend_next = {1'b0, face_reg, ent_slot_reg, ent_face_reg};
        end
        else if (cmd.push_full)
        begin
            pend_next = {1'b1, {IW{1'b0}}, opp_reg, face_reg};
        end
    end

    logic push;
    assign push = cmd.push_hit1 || cmd.push_hit2 || cmd.push_full;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            start_reg <= in_start;
            {v2_reg, v1_reg, v0_reg, face_reg} <= in_data;
        end
        if (cmd.setup_edge)
        begin
            lo_reg  <= lo_c;
            hi_reg  <= hi_c;
            opp_reg <= opp_c;
        end
        if (cmd.latch_entry)
        begin
            ent_face_reg <= rd_face;
            ent_slot_reg <= rd_slot;
        end
        if (push)
        begin
            pend_reg <= pend_next;
        end
        if ((push && pend_v_reg) || cmd.flush)
        begin
            out_reg      <= pend_reg;
            out_last_reg <= cmd.flush;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_reg   <= '0;
            addr_reg   <= '0;
            probes_reg <= '0;
            sweep_reg  <= '0;
            count_reg  <= '0;
            epoch_reg  <= meal_pkg::EPOCH_NONE;
            pend_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                edge_reg <= '0;
            end
            else if (cmd.next_edge)
            begin
                edge_reg <= edge_reg + 2'd1;
            end
            if (cmd.setup_edge)
            begin
                addr_reg   <= meal_pkg::key_slot_hash(lo_c, hi_c);
                probes_reg <= '0;
            end
            else if (cmd.probe_next)
            begin
                addr_reg   <= addr_reg + 1'b1;
                probes_reg <= probes_reg + 1'b1;
            end
            if (cmd.sweep_start)
            begin
                sweep_reg <= '0;
            end
            else if (cmd.sweep_wr)
            begin
                sweep_reg <= sweep_reg + 1'b1;
            end
            if (cmd.epoch_init)
            begin
                epoch_reg <= {{(meal_pkg::EPOCH_W-1){1'b0}}, 1'b1};
                count_reg <= '0;
            end
            else if (cmd.start_clear)
            begin
                epoch_reg <= epoch_reg + 1'b1;
                count_reg <= '0;
            end
            else if (cmd.write_entry)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (push)
            begin
                pend_v_reg <= 1'b1;
            end
            else if (cmd.flush)
            begin
                pend_v_reg <= 1'b0;
            end
            if ((push && pend_v_reg) || cmd.flush)
            begin
                out_v_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_v_reg <= 1'b0;
            end
        end
    end

    assign st.start_flag = start_reg;
    assign st.epoch_max  = (epoch_reg == meal_pkg::EPOCH_MAX);
    assign st.sweep_done = (sweep_reg == {AW{1'b1}});
    assign st.rd_valid   = (rd_epoch == epoch_reg);
    assign st.rd_match   = (rd_lo == lo_reg) && (rd_hi == hi_reg);
    assign st.probe_last = (probes_reg == {AW{1'b1}});
    assign st.edge_last  = (edge_reg == 2'd2);
    assign st.count_full = (count_reg == meal_pkg::CNT_W'(meal_pkg::TABLE_DEPTH));
    assign st.out_free   = !out_v_reg || out_ready;
    assign st.pend_valid = pend_v_reg;

    assign out_data  = {5'b0, out_reg};
    assign out_last  = out_last_reg;
    assign out_valid = out_v_reg;
endmodule

### rtl/core/meal_ctrl.sv
// Controller FSM: clearing sweep, per-edge probe loop and result issue.
// Depends on meal_pkg.
module meal_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  meal_pkg::meal_status_t st,
    output meal_pkg::meal_cmd_t    cmd
);
    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_START, S_SETUP, S_READ, S_CHECK,
        S_HIT1, S_HIT2, S_FULL, S_WRITE, S_NEXT, S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg, busy_next;   // sweep happens inside an item

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        busy_next  = busy_reg;
        unique case (state_reg)
            S_CLR:
            begin
                cmd.sweep_wr = 1'b1;
                if (st.sweep_done)
                begin
                    cmd.epoch_init = 1'b1;
                    state_next     = busy_reg ? S_SETUP : S_IDLE;
                    busy_next      = 1'b0;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                if (st.start_flag && st.epoch_max)
                begin
                    cmd.sweep_start = 1'b1;
                    busy_next       = 1'b1;
                    state_next      = S_CLR;
                end
                else
                begin
                    cmd.start_clear = st.start_flag;
                    state_next      = S_SETUP;
                end
            end
            S_SETUP:
            begin
                cmd.setup_edge = 1'b1;
                state_next     = S_READ;
            end
            S_READ:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                cmd.latch_entry = 1'b1;
                if (st.rd_valid && st.rd_match)
                begin
                    state_next = S_HIT1;
                end
                else if (!st.rd_valid)
                begin
                    state_next = S_WRITE;
                end
                else if (st.probe_last)
                begin
                    state_next = S_FULL;
                end
                else
                begin
                    cmd.probe_next = 1'b1;
                    state_next     = S_READ;
                end
            end
            S_HIT1:
            begin
                if (st.out_free)
                begin
                    cmd.push_hit1 = 1'b1;
                    state_next    = S_HIT2;
                end
            end
            S_HIT2:
            begin
                if (st.out_free)
                begin
                    cmd.push_hit2 = 1'b1;
                    state_next    = S_NEXT;
                end
            end
            S_FULL:
            begin
                if (st.out_free)
                begin
                    cmd.push_full = 1'b1;
                    state_next    = S_NEXT;
                end
            end
            S_WRITE:
            begin
                cmd.write_entry = 1'b1;
                state_next      = S_NEXT;
            end
            S_NEXT:
            begin
                if (st.edge_last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.next_edge = 1'b1;
                    state_next    = S_SETUP;
                end
            end
            S_DONE:
            begin
                if (!st.pend_valid)
                begin
                    state_next = S_IDLE;
                end
                else if (st.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);
endmodule

### rtl/core/mesh_edge_adjacency_linker_top.sv
// Top level of the mesh edge adjacency linker: controller plus datapath.
// Depends on meal_pkg, meal_ctrl, meal_datapath (and meal_ram beneath it).
//
// Use: triangles enter on the s_ channel, one word each; adjacency links
// leave on the m_ channel, zero to six words per triangle, tlast on the
// final link a triangle causes (a triangle that only stores edges gives none).
// Edges sit in a 4096-entry hashed table in one RAM, linear probing. Each
// entry carries a mesh epoch; start_mesh bumps the epoch so old entries read
// as empty, with no sweep.
// Steps: take the word and check start_mesh, then per edge setup, read and
// check, with read and check again per extra probe, then store the edge,
// emit a link pair or report a full table, a next-edge step after each
// edge, and a closing step; a new triangle is taken only once the last is
// done. A full table probes all 4096 slots per edge, and the probe loop
// through the single RAM read port dominates the time per triangle.
// Reset: a clearing sweep writes all 4096 entries with s_tready
// low; the same sweep runs inside an item when the epoch counter wraps.
// Stall: one link waits in a pending register and one in the output register;
// when m_tready is low the controller holds in its issue state.
// A word of the last link of a triangle leaves only once that triangle is done.
`include "mesh_edge_adjacency_linker_top_defines.svh"
module mesh_edge_adjacency_linker_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // face_id, vertex_a, vertex_b, vertex_c
    input  logic        s_tuser,   // start_mesh
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // target_face, target_slot, neighbor_face,
                                   // table_full, zero pad
    output logic        m_tlast
);
    meal_pkg::meal_cmd_t    cmd;
    meal_pkg::meal_status_t st;

    meal_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    meal_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .st        (st),
        .in_start  (s_tuser),
        .in_data   (s_tdata),
        .out_data  (m_tdata),
        .out_last  (m_tlast),
        .out_valid (m_tvalid),
        .out_ready (m_tready)
    );

    // checks on the controller/datapath contract
    `MEAL_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready,
        "input accepted while previous item still busy")
    `MEAL_ASSERT_NOW(a_no_insert_when_full, cmd.write_entry, !st.count_full,
        "edge inserted into a full table")
    `MEAL_ASSERT_NOW(a_push_needs_room,
        cmd.push_hit1 || cmd.push_hit2 || cmd.push_full || cmd.flush, st.out_free,
        "result issued with output register occupied")
endmodule

### tb/mesh_edge_adjacency_linker_checker.sv
// Link checker for the mesh edge adjacency linker: watches both channels,
// predicts the adjacency links from the accepted triangles and compares them.
// Depends on nothing but the channel signals.
module mesh_edge_adjacency_linker_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,   // face_id, vertex_a, vertex_b, vertex_c
    input  logic        s_tuser,   // start_mesh
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,   // target_face, target_slot, neighbor_face, table_full, pad
    input  logic        m_tlast,
    output int          fail_count,
    output int          links_pending
);
    localparam int EDGE_CAPACITY = 4096;

    typedef struct packed {
        logic [15:0] target_face;
        logic [1:0]  target_slot;
        logic [15:0] neighbor_face;
        logic        table_full;
        logic        last;
    } link_t;

    typedef struct packed {
        logic [15:0] face;
        logic [1:0]  slot;
    } edge_owner_t;

    edge_owner_t edge_owner[logic [31:0]];   // key: {lo vertex, hi vertex}
    int          edge_total;
    link_t       link_queue[$];

    assign links_pending = link_queue.size();

    task automatic predict_links(input logic start, input logic [63:0] word);
        logic [15:0] face;
        logic [15:0] vtx[3];
        logic [15:0] p, q;
        logic [31:0] key;
        logic [1:0]  opp;
        link_t       made[6];
        int          n_made;
        face   = word[15:0];
        vtx[0] = word[31:16];
        vtx[1] = word[47:32];
        vtx[2] = word[63:48];
        n_made = 0;
        if (start)
        begin
            edge_owner.delete();
            edge_total = 0;
        end
        for (int j = 0; j < 3; j++)
        begin
            p   = vtx[j];
            q   = vtx[(j + 1) % 3];
            key = (p < q) ? {p, q} : {q, p};
            opp = 2'((j + 2) % 3);
            if (edge_owner.exists(key))
            begin
                made[n_made] = '{face, opp, edge_owner[key].face, 1'b0, 1'b0};
                n_made++;
                made[n_made] = '{edge_owner[key].face, edge_owner[key].slot, face,
                                 1'b0, 1'b0};
                n_made++;
            end
            else if (edge_total >= EDGE_CAPACITY)
            begin
                made[n_made] = '{face, opp, 16'd0, 1'b1, 1'b0};
                n_made++;
            end
            else
            begin
                edge_owner[key] = '{face, opp};
                edge_total++;
            end
        end
        if (n_made > 0)
            made[n_made - 1].last = 1'b1;
        for (int i = 0; i < n_made; i++)
            link_queue.insert(link_queue.size(), made[i]);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        link_t seen, want;
        if (!rst_n)
        begin
            edge_owner.delete();
            edge_total = 0;
            link_queue.delete();
            fail_count = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                predict_links(s_tuser, s_tdata);
            if (m_tvalid && m_tready)
            begin
                seen = '{m_tdata[15:0], m_tdata[17:16], m_tdata[33:18], m_tdata[34], m_tlast};
                if (link_queue.size() == 0)
                begin
                    $display("%0t: unexpected link, actual %p", $time, seen);
                    fail_count++;
                end
                else
                begin
                    want = link_queue.pop_front();
                    if (seen !== want)
                    begin
                        $display("%0t: link mismatch, expected %p, actual %p",
                                 $time, want, seen);
                        fail_count++;
                    end
                end
            end
        end
    end
endmodule

### tb/tb_mesh_edge_adjacency_linker_top.sv
// Testbench top for the mesh edge adjacency linker: drives triangles with
// random gaps, stalls the link channel, and gives the verdict.
// Depends on mesh_edge_adjacency_linker_top and mesh_edge_adjacency_linker_checker.
module tb_mesh_edge_adjacency_linker_top;
    // idle cycles with no word moved on either side before giving up;
    // covers the clearing sweep after reset and on epoch wrap
    localparam int STALL_LIMIT = 40000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;    // face_id, vertex_a, vertex_b, vertex_c
    logic        s_tuser;    // start_mesh
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;    // target_face, target_slot, neighbor_face, table_full, pad
    logic        m_tlast;
    int          fail_count;
    int          links_pending;
    int          quiet_cycles;
    int          sink_hold;
    bit          no_gaps;    // set for burst stretches with no sender idling and no sink stall

    mesh_edge_adjacency_linker_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    mesh_edge_adjacency_linker_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .fail_count    (fail_count),
        .links_pending (links_pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Link sink: after each word taken, draw a random hold and keep tready low while it counts down.
    always @(posedge clk or negedge rst_n)
    begin
        int n;
        if (!rst_n)
        begin
            m_tready  <= 1'b1;
            sink_hold <= 0;
        end
        else if (m_tvalid && m_tready)
        begin
            n = no_gaps ? 0 : $urandom_range(0, 5);
            sink_hold <= n;
            m_tready  <= (n == 0);
        end
        else if (sink_hold > 0)
        begin
            sink_hold <= sink_hold - 1;
            m_tready  <= (sink_hold <= 1);
        end
    end

    // Watchdog: any word moved on either side resets the count.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // One triangle word: optional idle gap, then hold valid until taken.
    // Valid stays high straight into the next word when that word has no gap.
    task automatic send_face(input logic start, input logic [15:0] face,
                             input logic [15:0] va, input logic [15:0] vb,
                             input logic [15:0] vc);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= start;
        s_tdata  <= {vc, vb, va, face};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Random triangle, mostly drawn from a small vertex pool so edges repeat.
    task automatic send_random_face(input logic start, input int pool);
        logic [15:0] va, vb, vc;
        if (pool == 0)
        begin
            va = 16'($urandom);
            vb = 16'($urandom);
            vc = 16'($urandom);
        end
        else
        begin
            va = 16'($urandom_range(0, pool - 1));
            vb = 16'($urandom_range(0, pool - 1));
            vc = 16'($urandom_range(0, pool - 1));
        end
        send_face(start, 16'($urandom), va, vb, vc);
    endtask

    initial
    begin
        int pool;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tuser  = 1'b0;
        s_tdata  = '0;
        no_gaps  = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: fresh mesh, shared edges, repeated duplicates, extremes.
        send_face(1'b1, 16'h0000, 16'd0, 16'd1, 16'd2);          // stores only
        send_face(1'b0, 16'h0001, 16'd2, 16'd1, 16'd3);          // shares edge 1-2
        send_face(1'b0, 16'h0002, 16'd1, 16'd2, 16'd4);          // third use of 1-2
        send_face(1'b0, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h8000);
        send_face(1'b0, 16'h5555, 16'h8000, 16'hFFFF, 16'h0000); // all its edges seen
        send_face(1'b0, 16'hAAAA, 16'h7777, 16'h7777, 16'h7777); // degenerate: self links
        send_face(1'b0, 16'h1234, 16'h0100, 16'h0200, 16'h0100); // two equal vertices
        send_face(1'b1, 16'h0003, 16'd2, 16'd1, 16'd3);          // start clears old edges
        send_face(1'b0, 16'h0004, 16'd3, 16'd1, 16'd2);          // reversed vertex order
        send_face(1'b1, 16'h00FF, 16'hFF00, 16'h00FF, 16'hF0F0);
        send_face(1'b0, 16'hFF00, 16'h0F0F, 16'hF0F0, 16'h00FF);

        // Random meshes: each run opens with start_mesh, small vertex pools
        // make shared edges common; a few runs use the full vertex range.
        for (int run = 0; run < 13; run++)
        begin
            pool    = (run % 5 == 4) ? 0 : $urandom_range(3, 24);
            no_gaps = (run % 4 == 2);
            for (int i = 0; i < 15; i++)
                send_random_face(i == 0 || $urandom_range(0, 40) == 0, pool);
        end
        no_gaps = 1'b0;

        @(posedge clk);
        s_tvalid <= 1'b0;
        while (links_pending > 0)
            @(posedge clk);
        repeat (60) @(posedge clk);

        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

### sim.f
+incdir+rtl/core
rtl/core/meal_pkg.sv
rtl/core/meal_ram.sv
rtl/core/meal_datapath.sv
rtl/core/meal_ctrl.sv
rtl/core/mesh_edge_adjacency_linker_top.sv
tb/mesh_edge_adjacency_linker_checker.sv
tb/tb_mesh_edge_adjacency_linker_top.sv
